// ===== rtl/zbdt_pkg.sv =====
// ----------------------------------------------------------------------------
// zbdt_pkg
// shared constants, command and status types of the depth test block
// ----------------------------------------------------------------------------
package zbdt_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int DEPTH_BITS  = 24;
  localparam int TEX_DIM_MAX = 1024;

  localparam int SCR_W   = 10;   // screen register width
  localparam int POS_W   = 10;
  localparam int ZIN_W   = 24;   // depth field on the port
  localparam int PERSP_W = 32;
  localparam int TEX_W   = 11;   // texture size field, also quotient bits
  localparam int ID_W    = 8;
  localparam int TXL_W   = 10;   // texel address on the port
  localparam int FBO_W   = 18;

  // offset arithmetic, wide enough for the largest store (2^18 entries)
  localparam int OFF_W  = 26;
  localparam int PROD_W = PERSP_W + TEX_W + 1;
  localparam int REM_W  = PERSP_W + TEX_W;

  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;
  localparam logic [SCR_W-1:0] SCREEN_RESET = 10'd512;

  localparam logic OP_FRAGMENT = 1'b0;
  localparam logic OP_CLEAR    = 1'b1;

  typedef struct packed {
    logic load;
    logic calc;
    logic rd;
    logic wr_frag;
    logic clr_wr;
    logic div_start;
    logic div_step;
    logic out_load;
  } zbdt_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic frag_ok;
    logic pass;
    logic clr_last;
    logic div_last;
    logic out_busy;
  } zbdt_status_t;

endpackage

// ===== rtl/zbdt_ram.sv =====
// ----------------------------------------------------------------------------
// zbdt_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module zbdt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/zbdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// zbdt_ctrl
// sequencer: clear sweep, fragment address, depth read-modify-write, divide
// ----------------------------------------------------------------------------
module zbdt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output zbdt_pkg::zbdt_cmd_t    cmd,
  input  zbdt_pkg::zbdt_status_t st
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = st.op_clear ? S_CLEAR : S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.calc   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        if (st.frag_ok) begin
          cmd.rd     = 1'b1;
          state_next = S_CMP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CMP: begin
        if (st.pass) begin
          cmd.wr_frag   = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/zbdt_dp.sv =====
// ----------------------------------------------------------------------------
// zbdt_dp
// datapath: window test, offset, depth store, two texel dividers, output word
// ----------------------------------------------------------------------------
module zbdt_dp #(
  parameter int MAX_WIDTH  = zbdt_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = zbdt_pkg::MAX_HEIGHT,
  parameter int DEPTH_BITS = zbdt_pkg::DEPTH_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  zbdt_pkg::zbdt_cmd_t                   cmd,
  output zbdt_pkg::zbdt_status_t                st,
  input  logic [zbdt_pkg::SCR_W-1:0]           screen_width,
  input  logic [zbdt_pkg::SCR_W-1:0]           screen_height,
  input  logic                                 op,
  input  logic signed [zbdt_pkg::POS_W-1:0]    pos_x,
  input  logic signed [zbdt_pkg::POS_W-1:0]    pos_y,
  input  logic [zbdt_pkg::ZIN_W-1:0]           frag_depth,
  input  logic signed [zbdt_pkg::PERSP_W-1:0]  persp_u,
  input  logic signed [zbdt_pkg::PERSP_W-1:0]  persp_v,
  input  logic [zbdt_pkg::PERSP_W-1:0]         persp_w,
  input  logic [zbdt_pkg::TEX_W-1:0]           tex_width,
  input  logic [zbdt_pkg::TEX_W-1:0]           tex_height,
  input  logic [zbdt_pkg::ID_W-1:0]            tex_id,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [zbdt_pkg::FBO_W-1:0]           fb_offset,
  output logic signed [zbdt_pkg::POS_W-1:0]    out_x,
  output logic signed [zbdt_pkg::POS_W-1:0]    out_y,
  output logic [zbdt_pkg::TXL_W-1:0]           texel_u,
  output logic [zbdt_pkg::TXL_W-1:0]           texel_v,
  output logic [zbdt_pkg::ID_W-1:0]            out_tex_id,
  output logic                                 used_fallback
);

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int OFF_W      = zbdt_pkg::OFF_W;
  localparam int QB         = zbdt_pkg::TEX_W;
  localparam int PW         = zbdt_pkg::PROD_W;
  localparam int RW         = zbdt_pkg::REM_W;
  localparam int CW         = $clog2(QB);

  // latched fragment
  logic signed [zbdt_pkg::POS_W-1:0]   pos_x_r, pos_y_r;
  logic [DEPTH_BITS-1:0]               z_r;
  logic signed [zbdt_pkg::PERSP_W-1:0] pu_r, pv_r;
  logic [zbdt_pkg::PERSP_W-1:0]        pw_r;
  logic [QB-1:0]                       tw_r, th_r;
  logic [zbdt_pkg::ID_W-1:0]           id_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x_r <= pos_x;
      pos_y_r <= pos_y;
      z_r     <= DEPTH_BITS'(frag_depth);
      pu_r    <= persp_u;
      pv_r    <= persp_v;
      pw_r    <= persp_w;
      tw_r    <= tex_width;
      th_r    <= tex_height;
      id_r    <= tex_id;
    end
  end

  // window test and offset, (W*(H-2y) + 2x + W) >> 1
  logic [QB-1:0]           ax, ay;
  logic [QB-1:0]           xs, ys;
  logic signed [OFF_W-1:0] w_s, h_s, x_s, y_s, fterm, fsum, off_next;
  logic                    in_window;
  logic                    frag_ok_next;
  logic signed [OFF_W-1:0] off_r;
  logic                    frag_ok_r;

  always_comb begin
    xs = QB'(pos_x_r);
    ys = QB'(pos_y_r);
    ax = xs[QB-1] ? (~xs + 1'b1) : xs;
    ay = ys[QB-1] ? (~ys + 1'b1) : ys;
    in_window = ({ax, 1'b0} < (QB+1)'(screen_width)) &&
                ({ay, 1'b0} < (QB+1)'(screen_height));
    w_s      = OFF_W'(screen_width);
    h_s      = OFF_W'(screen_height);
    x_s      = OFF_W'(pos_x_r);
    y_s      = OFF_W'(pos_y_r);
    fterm    = h_s - (y_s <<< 1);
    fsum     = w_s * fterm + (x_s <<< 1) + w_s;
    off_next = fsum >>> 1;
    frag_ok_next = in_window && !off_next[OFF_W-1] &&
                   ($unsigned(off_next) < OFF_W'(STORE_SIZE));
  end

  // texel products, registered before the divide
  logic signed [PW-1:0] prod_u, prod_v;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      off_r  <= off_next;
      prod_u <= PW'(pu_r) * $signed({1'b0, tw_r});
      prod_v <= PW'(pv_r) * $signed({1'b0, th_r});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frag_ok_r <= 1'b0;
    end else if (cmd.calc) begin
      frag_ok_r <= frag_ok_next;
    end
  end

  // depth store and clear sweep
  logic [ADDR_W-1:0]     clr_idx;
  logic [DEPTH_BITS-1:0] rd_data;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [DEPTH_BITS-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_wr) begin
      clr_idx <= st.clr_last ? '0 : clr_idx + 1'b1;
    end
  end

  assign mem_we    = cmd.wr_frag | cmd.clr_wr;
  assign mem_waddr = cmd.clr_wr ? clr_idx : off_r[ADDR_W-1:0];
  assign mem_wdata = cmd.clr_wr ? '1 : z_r;

  zbdt_ram #(
    .WIDTH (DEPTH_BITS),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (cmd.rd),
    .raddr (off_r[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // restoring dividers, one quotient bit per cycle, shared divisor shifter
  logic [PW-1:0] abs_u, abs_v;
  logic [RW-1:0] mag_u, mag_v, wlim;
  logic [RW-1:0] rem_u, rem_v, dsr;
  logic [QB-1:0] q_u, q_v;
  logic          neg_u, neg_v, ovf_u, ovf_v;
  logic [CW-1:0] cnt;
  logic          ok_u, ok_v, ok_all;

  always_comb begin
    abs_u = prod_u[PW-1] ? (~prod_u + 1'b1) : prod_u;
    abs_v = prod_v[PW-1] ? (~prod_v + 1'b1) : prod_v;
    mag_u = abs_u[RW-1:0];
    mag_v = abs_v[RW-1:0];
    wlim  = RW'(pw_r) << QB;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_u <= mag_u;
      rem_v <= mag_v;
      neg_u <= prod_u[PW-1];
      neg_v <= prod_v[PW-1];
      ovf_u <= (mag_u >= wlim);
      ovf_v <= (mag_v >= wlim);
      dsr   <= RW'(pw_r) << (QB - 1);
      q_u   <= '0;
      q_v   <= '0;
      cnt   <= CW'(QB - 1);
    end else if (cmd.div_step) begin
      if (rem_u >= dsr) begin
        rem_u <= rem_u - dsr;
        q_u   <= {q_u[QB-2:0], 1'b1};
      end else begin
        q_u   <= {q_u[QB-2:0], 1'b0};
      end
      if (rem_v >= dsr) begin
        rem_v <= rem_v - dsr;
        q_v   <= {q_v[QB-2:0], 1'b1};
      end else begin
        q_v   <= {q_v[QB-2:0], 1'b0};
      end
      dsr <= dsr >> 1;
      cnt <= cnt - 1'b1;
    end
  end

  // negative term only survives when it truncates to zero
  always_comb begin
    ok_u = !ovf_u && (neg_u ? (q_u == '0) :
           ((q_u < tw_r) && (32'(q_u) < zbdt_pkg::TEX_DIM_MAX)));
    ok_v = !ovf_v && (neg_v ? (q_v == '0) :
           ((q_v < th_r) && (32'(q_v) < zbdt_pkg::TEX_DIM_MAX)));
    ok_all = (pw_r != '0) && ok_u && ok_v;
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fb_offset     <= off_r[zbdt_pkg::FBO_W-1:0];
      out_x         <= pos_x_r;
      out_y         <= pos_y_r;
      texel_u       <= ok_all ? q_u[zbdt_pkg::TXL_W-1:0] : zbdt_pkg::TXL_W'(1);
      texel_v       <= ok_all ? q_v[zbdt_pkg::TXL_W-1:0] : zbdt_pkg::TXL_W'(1);
      out_tex_id    <= id_r;
      used_fallback <= !ok_all;
    end
  end

  always_comb begin
    st          = '0;
    st.op_clear = (op == zbdt_pkg::OP_CLEAR);
    st.frag_ok  = frag_ok_r;
    st.pass     = (z_r < rd_data);
    st.clr_last = (clr_idx == ADDR_W'(STORE_SIZE - 1));
    st.div_last = (cnt == '0);
    st.out_busy = out_valid && !out_ready;
  end

`ifndef NO_ASSERTIONS
  a_write_only_nearer: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_frag |-> (z_r < rd_data))
    else $error("depth written without a passing test");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result overwritten while still held");
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_frag && cmd.clr_wr))
    else $error("fragment write during clear sweep");
  a_read_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> frag_ok_r)
    else $error("depth read for a dropped fragment");
`endif

endmodule

// ===== rtl/zbuffer_depth_test_texcoord_top.sv =====
// ----------------------------------------------------------------------------
// zbuffer_depth_test_texcoord_top
// depth-tested fragment stage with perspective-correct texel address
// ----------------------------------------------------------------------------
// fragments enter on in_valid/in_ready, one word at a time; op selects a
// fragment test or a clear of the whole depth store. a fragment inside the
// window that is strictly nearer than the stored depth updates the store and
// gives one word on out_valid/out_ready; every other fragment gives nothing.
// a fragment dropped by the window ends without a depth read, one that
// fails the depth test ends after the depth read, and one that passes goes
// on, after the depth read-modify-write on the single memory port, to the two
// texel dividers at one quotient bit per cycle. a clear writes every store
// entry (262144 at default sizes); reset starts the same sweep, during which
// in_ready stays low; the apb port still takes writes. the result sits in an
// output register: if the receiver stalls, the next fragment is still taken
// and worked on, and waits only when its own result is ready to be loaded.
// screen_width and screen_height lie at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module zbuffer_depth_test_texcoord_top #(
  parameter int MAX_WIDTH  = zbdt_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = zbdt_pkg::MAX_HEIGHT,
  parameter int DEPTH_BITS = zbdt_pkg::DEPTH_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [zbdt_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [zbdt_pkg::DATA_BITS-1:0]       pwdata,
  output logic [zbdt_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic signed [zbdt_pkg::POS_W-1:0]    pos_x,
  input  logic signed [zbdt_pkg::POS_W-1:0]    pos_y,
  input  logic [zbdt_pkg::ZIN_W-1:0]           frag_depth,
  input  logic signed [zbdt_pkg::PERSP_W-1:0]  persp_u,
  input  logic signed [zbdt_pkg::PERSP_W-1:0]  persp_v,
  input  logic [zbdt_pkg::PERSP_W-1:0]         persp_w,
  input  logic [zbdt_pkg::TEX_W-1:0]           tex_width,
  input  logic [zbdt_pkg::TEX_W-1:0]           tex_height,
  input  logic [zbdt_pkg::ID_W-1:0]            tex_id,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [zbdt_pkg::FBO_W-1:0]           fb_offset,
  output logic signed [zbdt_pkg::POS_W-1:0]    out_x,
  output logic signed [zbdt_pkg::POS_W-1:0]    out_y,
  output logic [zbdt_pkg::TXL_W-1:0]           texel_u,
  output logic [zbdt_pkg::TXL_W-1:0]           texel_v,
  output logic [zbdt_pkg::ID_W-1:0]            out_tex_id,
  output logic                                 used_fallback
);

  logic [zbdt_pkg::SCR_W-1:0] screen_width;
  logic [zbdt_pkg::SCR_W-1:0] screen_height;
  logic                       reg_wr;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= zbdt_pkg::SCREEN_RESET;
      screen_height <= zbdt_pkg::SCREEN_RESET;
    end else if (reg_wr) begin
      unique case (reg_sel)
        zbdt_pkg::REG_SCREEN_WIDTH:  screen_width  <= pwdata[zbdt_pkg::SCR_W-1:0];
        zbdt_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[zbdt_pkg::SCR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      zbdt_pkg::REG_SCREEN_WIDTH:  prdata = zbdt_pkg::DATA_BITS'(screen_width);
      zbdt_pkg::REG_SCREEN_HEIGHT: prdata = zbdt_pkg::DATA_BITS'(screen_height);
      default:                     prdata = '0;
    endcase
  end

  zbdt_pkg::zbdt_cmd_t    cmd;
  zbdt_pkg::zbdt_status_t st;

  zbdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  zbdt_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .op            (op),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .frag_depth    (frag_depth),
    .persp_u       (persp_u),
    .persp_v       (persp_v),
    .persp_w       (persp_w),
    .tex_width     (tex_width),
    .tex_height    (tex_height),
    .tex_id        (tex_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fb_offset     (fb_offset),
    .out_x         (out_x),
    .out_y         (out_y),
    .texel_u       (texel_u),
    .texel_v       (texel_v),
    .out_tex_id    (out_tex_id),
    .used_fallback (used_fallback)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the depth-tested fragment stage: a table of directed fragments, then
// random fragments under several window sizes, each result compared against
// an in-bench depth store and texel address calculation or, for directed
// rows, against a word written out by hand
module tb;

  localparam int MAX_WIDTH   = zbdt_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT  = zbdt_pkg::MAX_HEIGHT;
  localparam int TEX_DIM_MAX = zbdt_pkg::TEX_DIM_MAX;
  localparam int POS_W       = zbdt_pkg::POS_W;
  localparam int ZIN_W       = zbdt_pkg::ZIN_W;
  localparam int PERSP_W     = zbdt_pkg::PERSP_W;
  localparam int TEX_W       = zbdt_pkg::TEX_W;
  localparam int ID_W        = zbdt_pkg::ID_W;
  localparam int TXL_W       = zbdt_pkg::TXL_W;
  localparam int FBO_W       = zbdt_pkg::FBO_W;
  localparam int ADDR_BITS   = zbdt_pkg::ADDR_BITS;
  localparam int DATA_BITS   = zbdt_pkg::DATA_BITS;
  localparam logic OP_FRAGMENT       = zbdt_pkg::OP_FRAGMENT;
  localparam logic OP_CLEAR          = zbdt_pkg::OP_CLEAR;
  localparam logic REG_SCREEN_WIDTH  = zbdt_pkg::REG_SCREEN_WIDTH;
  localparam logic REG_SCREEN_HEIGHT = zbdt_pkg::REG_SCREEN_HEIGHT;
  localparam int unsigned SCREEN_RESET = zbdt_pkg::SCREEN_RESET;

  localparam int  STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  DRAIN_CYCLES = 40;
  localparam logic [ZIN_W-1:0] FARTHEST = '1;

  typedef struct {
    logic                     op;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [ZIN_W-1:0]         z;
    logic signed [31:0]       pu;
    logic signed [31:0]       pv;
    logic [31:0]              pw;
    logic [TEX_W-1:0]         tw;
    logic [TEX_W-1:0]         th;
    logic [ID_W-1:0]          id;
  } frag_t;

  typedef struct {
    logic [FBO_W-1:0]         off;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [TXL_W-1:0]         u;
    logic [TXL_W-1:0]         v;
    logic [ID_W-1:0]          id;
    logic                     fb;
  } pixel_t;

  typedef struct {
    frag_t  f;
    bit     typed;   // expected word written out by hand
    bit     none;    // hand-written: no word at all
    pixel_t p;
  } row_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic op = OP_FRAGMENT;
  logic signed [POS_W-1:0] pos_x = '0, pos_y = '0;
  logic [ZIN_W-1:0] frag_depth = '0;
  logic signed [PERSP_W-1:0] persp_u = '0, persp_v = '0;
  logic [PERSP_W-1:0] persp_w = '0;
  logic [TEX_W-1:0] tex_width = '0, tex_height = '0;
  logic [ID_W-1:0] tex_id = '0;
  logic out_valid, out_ready = 0;
  logic [FBO_W-1:0] fb_offset;
  logic signed [POS_W-1:0] out_x, out_y;
  logic [TXL_W-1:0] texel_u, texel_v;
  logic [ID_W-1:0] out_tex_id;
  logic used_fallback;

  zbuffer_depth_test_texcoord_top dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // shadow of the block
  logic [ZIN_W-1:0] depth_shadow [int];
  int unsigned win_w = SCREEN_RESET, win_h = SCREEN_RESET;
  pixel_t pixel_q[$];
  bit typed_now, typed_none;
  pixel_t typed_pixel;
  bit failed = 0, quiet = 0;
  int unsigned cycles = 0;

  function automatic bit texel_axis(longint term, longint size, longint w,
                                    output longint q);
    longint bound, prod;
    bound = size < TEX_DIM_MAX ? size : TEX_DIM_MAX;
    prod = term * size;
    if (prod < 0) begin
      q = (-prod) / w;
      if (q != 0) return 0;
    end else begin
      q = prod / w;
    end
    return q < bound;
  endfunction

  // returns 1 when the fragment draws; updates the shadow depth store
  function automatic bit depth_test_fragment(frag_t f, output pixel_t p);
    longint x, y, ax, ay, off, qu, qv, w;
    logic [ZIN_W-1:0] stored;
    bit ok;
    p = '{default: '0};
    if (f.op == OP_CLEAR) begin
      depth_shadow.delete();
      return 0;
    end
    x = f.x;
    y = f.y;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    if (!(2 * ax < win_w && 2 * ay < win_h)) return 0;
    off = (longint'(win_w) * (longint'(win_h) - 2 * y) + 2 * x + win_w) / 2;
    if (off < 0 || off >= STORE_SIZE) return 0;
    stored = depth_shadow.exists(int'(off)) ? depth_shadow[int'(off)] : FARTHEST;
    if (!(f.z < stored)) return 0;
    depth_shadow[int'(off)] = f.z;
    w = longint'(f.pw);
    ok = 0;
    if (w != 0)
      ok = texel_axis(longint'(f.pu), longint'(f.tw), w, qu) &&
           texel_axis(longint'(f.pv), longint'(f.th), w, qv);
    p.off = off[FBO_W-1:0];
    p.x = f.x;
    p.y = f.y;
    p.u = ok ? qu[TXL_W-1:0] : TXL_W'(1);
    p.v = ok ? qv[TXL_W-1:0] : TXL_W'(1);
    p.id = f.id;
    p.fb = !ok;
    return 1;
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      failed = 1;
    end
  endtask

  // sampling at the rising edge
  always @(posedge clk) begin
    frag_t f;
    pixel_t p, e;
    cycles <= cycles + 1;
    if (!rst && in_valid && in_ready) begin
      f = '{op, pos_x, pos_y, frag_depth, persp_u, persp_v, persp_w,
            tex_width, tex_height, tex_id};
      if (depth_test_fragment(f, p) && !typed_now) pixel_q.push_back(p);
      if (typed_now && !typed_none) pixel_q.push_back(typed_pixel);
    end
    if (!rst && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected word, fb_offset %0d", fb_offset);
        failed = 1;
      end else begin
        e = pixel_q.pop_front();
        check_field("fb_offset", e.off, fb_offset);
        check_field("out_x", e.x, out_x);
        check_field("out_y", e.y, out_y);
        check_field("texel_u", e.u, texel_u);
        check_field("texel_v", e.v, texel_v);
        check_field("out_tex_id", e.id, out_tex_id);
        check_field("used_fallback", e.fb, used_fallback);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (quiet || stall == 0) begin
        out_ready = 1;
        if (!quiet && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 17);
      end else begin
        out_ready = 0;
        stall--;
      end
    end
  end

  task automatic apb_write(int idx, int unsigned val);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = ADDR_BITS'(4 * idx);
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    if (idx == REG_SCREEN_WIDTH) win_w = val & 32'h3FF;
    else win_h = val & 32'h3FF;
  endtask

  task automatic send_frag(frag_t f);
    @(negedge clk);
    in_valid = 1;
    op = f.op;
    pos_x = f.x;
    pos_y = f.y;
    frag_depth = f.z;
    persp_u = f.pu;
    persp_v = f.pv;
    persp_w = f.pw;
    tex_width = f.tw;
    tex_height = f.th;
    tex_id = f.id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 17)) begin
        @(negedge clk);
        in_valid = 0;
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic frag_t random_frag();
    frag_t f;
    int hx, hy, k;
    f.op = OP_FRAGMENT;
    hx = win_w / 2 + 2;
    hy = win_h / 2 + 2;
    if (hx > 511) hx = 511;
    if (hy > 511) hy = 511;
    f.x = $urandom_range(0, 7) == 0 ? POS_W'($urandom) : POS_W'(-hx + $urandom_range(0, 2 * hx));
    if ($urandom_range(0, 7) == 0) f.y = POS_W'($urandom);
    else if ($urandom_range(0, 3) == 0) f.y = POS_W'(hy - $urandom_range(0, 4));
    else f.y = POS_W'(-hy + $urandom_range(0, 2 * hy));
    f.z = ZIN_W'($urandom);
    f.tw = $urandom_range(0, 9) == 0 ? TEX_W'($urandom) : TEX_W'($urandom_range(1, 1024));
    f.th = $urandom_range(0, 9) == 0 ? TEX_W'($urandom) : TEX_W'($urandom_range(1, 1024));
    f.id = ID_W'($urandom);
    k = $urandom_range(0, 9);
    if (k == 0) begin
      f.pw = 0;
      f.pu = $urandom;
      f.pv = $urandom;
    end else if (k < 3) begin
      f.pw = $urandom;
      f.pu = $urandom;
      f.pv = $urandom;
    end else begin
      // terms scaled so the texel lands mostly in range
      f.pw = $urandom_range(1, 32'hFFFF_FFFF);
      f.pu = 32'((f.pw / (f.tw == 0 ? 1 : f.tw)) * $urandom_range(0, 1100));
      f.pv = 32'((f.pw / (f.th == 0 ? 1 : f.th)) * $urandom_range(0, 1100));
      if (f.pu < 0) f.pu = -f.pu;
      if (f.pv < 0) f.pv = -f.pv;
      if ($urandom_range(0, 7) == 0) f.pu = -f.pu;
      if ($urandom_range(0, 7) == 0) f.pv = -$urandom_range(0, 3);
    end
    return f;
  endfunction

  row_t dir_rows[$];
  int unsigned phase_w[8] = '{512, 2, 1023, 0, 100, 512, 2, 511};
  int unsigned phase_h[8] = '{512, 2, 1023, 1, 37, 2, 512, 300};

  function automatic row_t mk(logic o, int x, int y, int z, int pu, int pv,
                              int unsigned pw, int tw, int th, int id);
    row_t r;
    r.f = '{o, POS_W'(x), POS_W'(y), ZIN_W'(z), pu, pv, pw, TEX_W'(tw),
            TEX_W'(th), ID_W'(id)};
    r.typed = 0;
    r.none = 0;
    r.p = '{default: '0};
    return r;
  endfunction

  initial begin
    row_t r;
    frag_t f;
    // centre pixel at reset, zero w falls back
    r = mk(OP_FRAGMENT, 0, 0, 0, 5, 5, 0, 64, 64, 8'hAA);
    r.typed = 1;
    r.p = '{131328, 0, 0, 1, 1, 8'hAA, 1};
    dir_rows.push_back(r);
    // equal depth never passes
    r = mk(OP_FRAGMENT, 0, 0, 0, 0, 0, 1, 1, 1, 1);
    r.typed = 1;
    r.none = 1;
    dir_rows.push_back(r);
    // bottom right corner, last store entry
    r = mk(OP_FRAGMENT, 255, -255, 24'hFFFFFE, 0, 0, 0, 1, 1, 8'h55);
    r.typed = 1;
    r.p = '{262143, 255, -255, 1, 1, 8'h55, 1};
    dir_rows.push_back(r);
    // farthest depth against a fresh entry
    r = mk(OP_FRAGMENT, -255, 255, 24'hFFFFFF, 0, 0, 1, 1, 1, 0);
    r.typed = 1;
    r.none = 1;
    dir_rows.push_back(r);
    r = mk(OP_FRAGMENT, 256, 0, 0, 0, 0, 1, 1, 1, 0);
    r.typed = 1;
    r.none = 1;
    dir_rows.push_back(r);
    r = mk(OP_FRAGMENT, -512, -512, 0, 0, 0, 1, 1, 1, 0);
    r.typed = 1;
    r.none = 1;
    dir_rows.push_back(r);
    r = mk(OP_FRAGMENT, 0, 256, 0, 0, 0, 1, 1, 1, 0);
    r.typed = 1;
    r.none = 1;
    dir_rows.push_back(r);
    dir_rows.push_back(mk(OP_FRAGMENT, -255, 255, 3, 0, 0, 1, 1, 1, 1));
    dir_rows.push_back(mk(OP_FRAGMENT, 10, 20, 5, 1 << 16, 1 << 16, 1 << 20,
                          1024, 1024, 2));
    // small negative term truncates to zero
    dir_rows.push_back(mk(OP_FRAGMENT, 11, 20, 5, -1, -1, 1 << 20, 1, 1, 3));
    dir_rows.push_back(mk(OP_FRAGMENT, 12, 20, 5, -(1 << 20), 0, 1 << 20, 4, 4, 4));
    // texel exactly at the size bound
    dir_rows.push_back(mk(OP_FRAGMENT, 13, 20, 5, 1 << 20, 0, 1 << 20, 16, 16, 5));
    dir_rows.push_back(mk(OP_FRAGMENT, 14, 20, 5, 0, 0, 1 << 20, 0, 16, 6));
    dir_rows.push_back(mk(OP_FRAGMENT, 15, 20, 5, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'hFFFFFFFF, 2047, 2047, 255));
    dir_rows.push_back(mk(OP_FRAGMENT, 16, 20, 5, 32'h80000000, 32'h80000000,
                          32'hFFFFFFFF, 2047, 2047, 7));
    dir_rows.push_back(mk(OP_FRAGMENT, 17, 20, 5, 32'h1FFFFF, 32'h3FFFFF,
                          32'h100000, 1024, 512, 9));
    dir_rows.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // after a clear the centre entry is farthest again
    dir_rows.push_back(mk(OP_FRAGMENT, 0, 0, 24'hFFFFFE, 0, 0, 7, 3, 3, 8));
    dir_rows.push_back(mk(OP_FRAGMENT, 255, -255, 24'hFFFFFE, 0, 0, 7, 3, 3, 8));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    apb_write(REG_SCREEN_WIDTH, 512);
    apb_write(REG_SCREEN_HEIGHT, 512);

    // row flags change only at a falling edge, away from the accepting edge
    foreach (dir_rows[i]) begin
      @(negedge clk);
      typed_now = dir_rows[i].typed;
      typed_none = dir_rows[i].none;
      typed_pixel = dir_rows[i].p;
      send_frag(dir_rows[i].f);
    end
    wait_idle();
    typed_now = 0;

    for (int ph = 0; ph < 8; ph++) begin
      apb_write(REG_SCREEN_WIDTH, phase_w[ph]);
      apb_write(REG_SCREEN_HEIGHT, phase_h[ph]);
      if (ph == 7) quiet = 1;
      for (int n = 0; n < 70; n++) begin
        f = random_frag();
        if (ph == 4 && n == 30) f.op = OP_CLEAR;
        send_frag(f);
      end
      wait_idle();
    end

    if (!failed) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
